// ----- rtl/great_circle_distance_core_macros.svh -----
// ----------------------------------------------------------------------------
// Great-circle distance core: assertion macros
// Shared concurrent assertion forms for the distance core RTL.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH

// same-cycle implication
`define GCD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance package
// Widths, types and CORDIC constants shared by the distance core modules.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int STEPS   = 30;          // CORDIC micro-rotations
  localparam int CW      = 33;          // CORDIC datapath width, Q30
  localparam int ANG_W   = 26;          // angle in degrees, Q17
  localparam int ROOT_W  = 31;          // square root result width
  localparam int RAD_W   = 62;          // square root radicand width
  localparam int SC_LAT  = STEPS + 4;   // sine/cosine unit latency
  localparam int SQ_LAT  = ROOT_W + 1;  // square root unit latency
  localparam int AT_LAT  = STEPS + 1;   // atan2 unit latency

  typedef logic signed [CW-1:0]    cw_t;
  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic [RAD_W-1:0]        rad_t;
  typedef logic [14:0]             km_t;

  // pipeline control handed to each unit
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // configuration register indexes
  localparam logic [0:0] REG_ORIGIN_LAT = 1'd0;
  localparam logic [0:0] REG_ORIGIN_LNG = 1'd1;

  localparam logic signed [23:0] ORIGIN_LAT_RESET = -24'sd1341502;
  localparam logic signed [24:0] ORIGIN_LNG_RESET = -25'sd3579584;

  localparam logic signed [26:0] FULL_TURN    = 27'sd47185920;
  localparam logic signed [26:0] HALF_TURN    = 27'sd23592960;
  localparam logic signed [26:0] QUARTER_TURN = 27'sd11796480;

  localparam logic [ROOT_W-1:0]   ONE_Q30       = 31'h4000_0000;
  localparam logic signed [15:0]  EARTH_DIAM_KM = 16'sd12742;
  localparam km_t                 MAX_KM        = 15'd20015;

  // series selectors for the arctangent constant builder
  localparam int SERIES_INV5   = 0;
  localparam int SERIES_INV239 = 1;
  localparam int SERIES_POW2   = 2;

  localparam longint unsigned ONE62 = 64'h4000_0000_0000_0000;
  localparam longint unsigned ONE60 = 64'h1000_0000_0000_0000;

  // restoring long division, truncating quotient
  function automatic longint unsigned udiv_u64(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q;
    logic [64:0]     rem;
    q   = 0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // alternating arctangent series in Q62, truncating divisions
  function automatic longint atan_series(input longint unsigned first, input int mode,
                                         input int sh);
    longint unsigned pw;
    longint unsigned k;
    longint          sum;
    longint          term;
    pw  = first;
    sum = 0;
    k   = 0;
    while (pw != 0) begin
      term = longint'(udiv_u64(pw, 64'd2 * k + 64'd1));
      sum  = k[0] ? sum - term : sum + term;
      case (mode)
        SERIES_INV5:   pw = pw / 64'd25;
        SERIES_INV239: pw = pw / 64'd57121;
        default:       pw = pw >> sh;
      endcase
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic longint pi4_q62();
    return 4 * atan_series(ONE62 / 64'd5, SERIES_INV5, 0)
           - atan_series(ONE62 / 64'd239, SERIES_INV239, 0);
  endfunction

  // atan(2^-i) in Q30
  function automatic longint atan_entry(input int i);
    longint a;
    if (i == 0) begin
      a = pi4_q62();
    end else begin
      a = atan_series(ONE62 >> i, SERIES_POW2, 2 * i);
    end
    return (a + 64'sd2147483648) >>> 32;
  endfunction

  function automatic longint deg2rad_q40();
    return (pi4_q62() / 45 + 64'sd2097152) >>> 22;
  endfunction

  function automatic longint unsigned isqrt_u64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // reciprocal of the CORDIC gain in Q30
  function automatic longint cordic_start_q30();
    longint unsigned p;
    longint unsigned s;
    p = ONE60;
    for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
    s = isqrt_u64(p);
    return longint'(udiv_u64(ONE60 + (s >> 1), s));
  endfunction

  localparam logic signed [35:0] DEG2RAD_Q40  = 36'(deg2rad_q40());
  localparam cw_t                CORDIC_START = CW'(cordic_start_q30());

endpackage

// ----- rtl/great_circle_distance_core.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance core
// Haversine distance in whole km from a configured origin to each target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a target latitude and longitude
//   in degrees with 16 fraction bits. Each transaction yields exactly one
//   result transaction on out_valid/out_ready: the distance in km, rounded
//   and saturated at 20015.
//   The origin is set through cfg_we/cfg_index/cfg_wdata; the user must do so
//   only while idle, as the core itself does not enforce it. A target passes
//   through four parallel sine/cosine CORDICs, four product stages, two
//   parallel square roots, the atan2 CORDIC, scaling and the output register.
//   Throughput is one transaction per cycle while the pipeline advances.
//   All stages share one advance enable: the pipeline moves whenever its last
//   stage is empty or the output register can take a result, so new inputs
//   are still taken while a result waits, until the pipeline backs up.
//   A receiver stall holds every stage; nothing is lost or repeated.
//   Reset (synchronous, active low) empties the pipeline and restores the
//   default origin.
// ----------------------------------------------------------------------------
`include "great_circle_distance_core_macros.svh"

module great_circle_distance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_target_lat,
  input  logic signed [24:0] in_target_lng,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_dist_km,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [24:0]        cfg_wdata
);

  logic signed [23:0] origin_lat_r;
  logic signed [24:0] origin_lng_r;

  logic               en;
  gcd_pkg::pipe_ctl_t ctl;

  gcd_pkg::angle_t ang_dlat_r, ang_dlng_r, ang_o2_r, ang_t2_r;
  logic            va_r;

  gcd_pkg::cw_t s_dlat, s_dlng, c1, c2;
  logic         sc_vld;

  logic signed [65:0] p_cc_r, p_sl_r, p_sa_r, p_t_r;
  gcd_pkg::cw_t       cc_r, sl_r, sa_r, sa2_r;
  logic               v_m1_r, v_m2_r, v_m3_r, v_m4_r;
  logic signed [33:0] a_sum;
  gcd_pkg::root_t     a_r;
  gcd_pkg::root_t     a_nxt;

  gcd_pkg::pipe_ctl_t ctl_sq;
  gcd_pkg::root_t     root_a, root_b;
  logic               sq_vld;
  gcd_pkg::pipe_ctl_t ctl_at;
  gcd_pkg::cw_t       z_at;
  logic               at_vld;

  logic signed [47:0] dist_r;
  logic               v_f_r;
  logic signed [17:0] km_rnd;
  gcd_pkg::km_t       km_nxt;

  logic               out_valid_r;
  gcd_pkg::km_t       out_km_r;

  // advance when the last stage is empty or the output slot frees up
  assign en       = !v_f_r || !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lat_r <= gcd_pkg::ORIGIN_LAT_RESET;
      origin_lng_r <= gcd_pkg::ORIGIN_LNG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gcd_pkg::REG_ORIGIN_LAT: origin_lat_r <= cfg_wdata[23:0];
        gcd_pkg::REG_ORIGIN_LNG: origin_lng_r <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  // half-angle differences and doubled latitudes, all in Q17 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      ang_dlat_r <= gcd_pkg::ANG_W'(25'(in_target_lat) - 25'(origin_lat_r));
      ang_dlng_r <= gcd_pkg::ANG_W'(26'(in_target_lng) - 26'(origin_lng_r));
      ang_o2_r   <= {origin_lat_r[23], origin_lat_r, 1'b0};
      ang_t2_r   <= {in_target_lat[23], in_target_lat, 1'b0};
    end
  end

  assign ctl = '{en: en, vld: va_r};

  gcd_sincos u_sc_dlat (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl), .angle_i(ang_dlat_r),
    .sin_o(s_dlat), .cos_o(), .vld_o(sc_vld)
  );
  gcd_sincos u_sc_dlng (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl), .angle_i(ang_dlng_r),
    .sin_o(s_dlng), .cos_o(), .vld_o()
  );
  gcd_sincos u_sc_olat (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl), .angle_i(ang_o2_r),
    .sin_o(), .cos_o(c1), .vld_o()
  );
  gcd_sincos u_sc_tlat (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl), .angle_i(ang_t2_r),
    .sin_o(), .cos_o(c2), .vld_o()
  );

  // haversine term: sin^2(dlat) + cos1*cos2*sin^2(dlng)
  always_comb begin
    a_sum = 34'(sa2_r) + 34'(p_t_r >>> 30);
    if (a_sum < 0) begin
      a_nxt = '0;
    end else if (a_sum > 34'(gcd_pkg::ONE_Q30)) begin
      a_nxt = gcd_pkg::ONE_Q30;
    end else begin
      a_nxt = gcd_pkg::ROOT_W'(a_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cc_r <= c1 * c2;
      p_sl_r <= s_dlng * s_dlng;
      p_sa_r <= s_dlat * s_dlat;
      cc_r   <= gcd_pkg::CW'(p_cc_r >>> 30);
      sl_r   <= gcd_pkg::CW'(p_sl_r >>> 30);
      sa_r   <= gcd_pkg::CW'(p_sa_r >>> 30);
      p_t_r  <= cc_r * sl_r;
      sa2_r  <= sa_r;
      a_r    <= a_nxt;
    end
  end

  assign ctl_sq = '{en: en, vld: v_m4_r};

  gcd_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_sq),
    .rad_i(gcd_pkg::RAD_W'({a_r, 30'd0})),
    .root_o(root_a), .vld_o(sq_vld)
  );
  gcd_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_sq),
    .rad_i(gcd_pkg::RAD_W'({gcd_pkg::ONE_Q30 - a_r, 30'd0})),
    .root_o(root_b), .vld_o()
  );

  assign ctl_at = '{en: en, vld: sq_vld};

  gcd_atan2 u_atan2 (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl_at),
    .y_i(root_a), .x_i(root_b), .angle_o(z_at), .vld_o(at_vld)
  );

  // round half up to whole km, clamp to [0, MAX_KM]
  always_comb begin
    km_rnd = 18'((dist_r + 48'sd536870912) >>> 30);
    if (km_rnd < 0) begin
      km_nxt = '0;
    end else if (km_rnd > 18'(gcd_pkg::MAX_KM)) begin
      km_nxt = gcd_pkg::MAX_KM;
    end else begin
      km_nxt = 15'(km_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= z_at * gcd_pkg::EARTH_DIAM_KM;
    end
    if (en && v_f_r) begin
      out_km_r <= km_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      v_m1_r      <= 1'b0;
      v_m2_r      <= 1'b0;
      v_m3_r      <= 1'b0;
      v_m4_r      <= 1'b0;
      v_f_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        va_r   <= in_valid;
        v_m1_r <= sc_vld;
        v_m2_r <= v_m1_r;
        v_m3_r <= v_m2_r;
        v_m4_r <= v_m3_r;
        v_f_r  <= at_vld;
      end
      if (en && v_f_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dist_km = out_km_r;

  `GCD_ASSERT_NOW(a_km_range, clk, rst_n, out_valid_r, out_km_r <= gcd_pkg::MAX_KM, "distance above saturation limit")
  `GCD_ASSERT_NOW(a_stall_cause, clk, rst_n, !en, out_valid_r && !out_ready && v_f_r, "pipeline held without a blocked result")
  `GCD_ASSERT_NOW(a_hav_clamp, clk, rst_n, v_m4_r, a_r <= gcd_pkg::ONE_Q30, "haversine term above one")
  `GCD_ASSERT_NEXT(a_result_load, clk, rst_n, en && v_f_r, out_valid_r, "finished result not loaded")

endmodule

// ----- rtl/gcd_sincos.sv -----
// ----------------------------------------------------------------------------
// Sine/cosine unit
// Wraps a Q17 degree angle to a quarter turn, scales it to radians and runs
// a fully pipelined rotation CORDIC, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module gcd_sincos (
  input  logic                clk,
  input  logic                rst_n,
  input  gcd_pkg::pipe_ctl_t  ctl_i,
  input  gcd_pkg::angle_t     angle_i,
  output gcd_pkg::cw_t        sin_o,
  output gcd_pkg::cw_t        cos_o,
  output logic                vld_o
);

  localparam int LAT = gcd_pkg::SC_LAT;

  logic signed [26:0] m_ext;
  logic signed [26:0] m_wrap;
  logic signed [26:0] m_fold;
  logic               flip_nxt;
  logic signed [24:0] m_r;
  logic signed [60:0] prod_nxt;
  logic signed [60:0] prod_r;
  gcd_pkg::cw_t       z_nxt;

  gcd_pkg::cw_t x_r [0:gcd_pkg::STEPS];
  gcd_pkg::cw_t y_r [0:gcd_pkg::STEPS];
  gcd_pkg::cw_t z_r [0:gcd_pkg::STEPS];
  logic         v_r [0:LAT-1];
  logic         flip_r [0:LAT-1];
  gcd_pkg::cw_t sin_r;
  gcd_pkg::cw_t cos_r;

  // wrap into [-180,180) and fold into [-90,90]
  always_comb begin
    m_ext = 27'(angle_i);
    if (m_ext >= gcd_pkg::HALF_TURN) begin
      m_wrap = m_ext - gcd_pkg::FULL_TURN;
    end else if (m_ext < -gcd_pkg::HALF_TURN) begin
      m_wrap = m_ext + gcd_pkg::FULL_TURN;
    end else begin
      m_wrap = m_ext;
    end
    flip_nxt = 1'b1;
    if (m_wrap > gcd_pkg::QUARTER_TURN) begin
      m_fold = gcd_pkg::HALF_TURN - m_wrap;
    end else if (m_wrap < -gcd_pkg::QUARTER_TURN) begin
      m_fold = -gcd_pkg::HALF_TURN - m_wrap;
    end else begin
      m_fold   = m_wrap;
      flip_nxt = 1'b0;
    end
  end

  assign prod_nxt = m_r * gcd_pkg::DEG2RAD_Q40;
  assign z_nxt    = gcd_pkg::CW'((prod_r + 61'sd67108864) >>> 27);

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      m_r    <= 25'(m_fold);
      prod_r <= prod_nxt;
      x_r[0] <= gcd_pkg::CORDIC_START;
      y_r[0] <= '0;
      z_r[0] <= z_nxt;
      sin_r  <= y_r[gcd_pkg::STEPS];
      cos_r  <= flip_r[LAT-2] ? -x_r[gcd_pkg::STEPS] : x_r[gcd_pkg::STEPS];
    end
  end

  for (genvar i = 0; i < gcd_pkg::STEPS; i++) begin : g_stage
    localparam gcd_pkg::cw_t ATAN_I = gcd_pkg::CW'(gcd_pkg::atan_entry(i));
    gcd_pkg::cw_t dx;
    gcd_pkg::cw_t dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        v_r[k]    <= 1'b0;
        flip_r[k] <= 1'b0;
      end
    end else if (ctl_i.en) begin
      v_r[0]    <= ctl_i.vld;
      flip_r[0] <= flip_nxt;
      for (int k = 1; k < LAT; k++) begin
        v_r[k]    <= v_r[k-1];
        flip_r[k] <= flip_r[k-1];
      end
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
  assign vld_o = v_r[LAT-1];

endmodule

// ----- rtl/gcd_isqrt.sv -----
// ----------------------------------------------------------------------------
// Square root unit
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  gcd_pkg::pipe_ctl_t  ctl_i,
  input  gcd_pkg::rad_t       rad_i,
  output gcd_pkg::root_t      root_o,
  output logic                vld_o
);

  localparam int N = gcd_pkg::ROOT_W;

  gcd_pkg::rad_t v_r [0:N];
  gcd_pkg::rad_t r_r [0:N];
  logic          vl_r [0:N];

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      v_r[0] <= rad_i;
      r_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam gcd_pkg::rad_t BIT_J = gcd_pkg::RAD_W'(1) << (2 * (N - 1 - j));
    gcd_pkg::rad_t trial;
    assign trial = r_r[j] + BIT_J;
    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        if (v_r[j] >= trial) begin
          v_r[j+1] <= v_r[j] - trial;
          r_r[j+1] <= (r_r[j] >> 1) + BIT_J;
        end else begin
          v_r[j+1] <= v_r[j];
          r_r[j+1] <= r_r[j] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) vl_r[k] <= 1'b0;
    end else if (ctl_i.en) begin
      vl_r[0] <= ctl_i.vld;
      for (int k = 1; k <= N; k++) vl_r[k] <= vl_r[k-1];
    end
  end

  assign root_o = r_r[N][N-1:0];
  assign vld_o  = vl_r[N];

endmodule

// ----- rtl/gcd_atan2.sv -----
// ----------------------------------------------------------------------------
// Arctangent unit
// Pipelined vectoring CORDIC giving atan2(y, x) in Q30 radians for x, y >= 0.
// ----------------------------------------------------------------------------
module gcd_atan2 (
  input  logic                clk,
  input  logic                rst_n,
  input  gcd_pkg::pipe_ctl_t  ctl_i,
  input  gcd_pkg::root_t      y_i,
  input  gcd_pkg::root_t      x_i,
  output gcd_pkg::cw_t        angle_o,
  output logic                vld_o
);

  localparam int N = gcd_pkg::STEPS;

  gcd_pkg::cw_t x_r [0:N];
  gcd_pkg::cw_t y_r [0:N];
  gcd_pkg::cw_t z_r [0:N];
  logic         v_r [0:N];

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      x_r[0] <= gcd_pkg::CW'(x_i);
      y_r[0] <= gcd_pkg::CW'(y_i);
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam gcd_pkg::cw_t ATAN_I = gcd_pkg::CW'(gcd_pkg::atan_entry(i));
    gcd_pkg::cw_t dx;
    gcd_pkg::cw_t dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) v_r[k] <= 1'b0;
    end else if (ctl_i.en) begin
      v_r[0] <= ctl_i.vld;
      for (int k = 1; k <= N; k++) v_r[k] <= v_r[k-1];
    end
  end

  assign angle_o = z_r[N];
  assign vld_o   = v_r[N];

endmodule

// ----- dv/great_circle_distance_checker.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance checker
// Watches the target and distance channels and the origin register writes.
// For each target it computes the haversine distance with its own CORDIC
// arithmetic, queues the result and compares it with the next distance out.
// ----------------------------------------------------------------------------
module great_circle_distance_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_target_lat,
  input  logic signed [24:0] in_target_lng,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [14:0]        out_dist_km,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [24:0]        cfg_wdata,
  output int                 n_fail,
  output int                 n_pending,
  output int                 n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ROT_STEPS = 30;
  localparam longint Q30       = 64'sd1 << 30;
  localparam longint TURN      = 64'sd360 << 17;
  localparam longint HALF      = 64'sd180 << 17;
  localparam longint QUARTER   = 64'sd90 << 17;
  localparam longint DIAMETER  = 64'sd12742;
  localparam longint KM_CAP    = 64'sd20015;

  longint atan_tab [ROT_STEPS];
  longint deg_to_rad;
  longint gain_comp;
  longint org_lat;
  longint org_lng;
  logic [14:0] km_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, root, b;
    v    = v_in;
    root = 0;
    b    = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v    = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // alternating arctangent series in Q62
  function automatic longint arctan_q62(input longint unsigned first,
                                        input longint unsigned div);
    longint unsigned pw, k;
    longint acc, term;
    pw  = first;
    acc = 0;
    k   = 0;
    while (pw != 0) begin
      term = longint'(pw / (2 * k + 1));
      acc  = k[0] ? acc - term : acc + term;
      pw   = pw / div;
      k++;
    end
    return acc;
  endfunction

  initial begin
    longint unsigned one62, p, s;
    longint quarter_pi;
    one62 = 64'd1 << 62;
    quarter_pi = 4 * arctan_q62(one62 / 5, 25) - arctan_q62(one62 / 239, 57121);
    atan_tab[0] = (quarter_pi + (64'sd1 << 31)) >>> 32;
    for (int i = 1; i < ROT_STEPS; i++)
      atan_tab[i] = (arctan_q62(one62 >> i, 64'd1 << (2 * i)) + (64'sd1 << 31)) >>> 32;
    deg_to_rad = (quarter_pi / 45 + (64'sd1 << 21)) >>> 22;
    p = 64'd1 << 60;
    for (int i = 0; i < ROT_STEPS; i++) p = p + (p >> (2 * i));
    s = int_sqrt(p);
    gain_comp = longint'(((64'd1 << 60) + s / 2) / s);
  end

  // sine and cosine in Q30 of an angle in degrees Q17
  function automatic void rotate(input longint deg, output longint sn, output longint cs);
    longint m, x, y, z, dx, dy;
    bit     flip;
    m    = deg % TURN;
    flip = 0;
    if (m < 0) m += TURN;
    if (m >= HALF) m -= TURN;
    if (m > QUARTER) begin
      m    = HALF - m;
      flip = 1;
    end else if (m < -QUARTER) begin
      m    = -HALF - m;
      flip = 1;
    end
    z = (m * deg_to_rad + (64'sd1 << 26)) >>> 27;
    x = gain_comp;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint vector_angle(input longint y_in, input longint x_in);
    longint x, y, z, dx, dy;
    x = x_in;
    y = y_in;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic logic [14:0] haversine_km(input longint lat2, input longint lng2);
    longint s_lat, s_lng, c1, c2, unused, cc, a, ra, rb, d;
    rotate(lat2 - org_lat, s_lat, unused);
    rotate(lng2 - org_lng, s_lng, unused);
    rotate(org_lat * 2, unused, c1);
    rotate(lat2 * 2, unused, c2);
    cc = (c1 * c2) >>> 30;
    a  = ((s_lat * s_lat) >>> 30) + ((cc * ((s_lng * s_lng) >>> 30)) >>> 30);
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    ra = longint'(int_sqrt(longint'(a) << 30));
    rb = longint'(int_sqrt(longint'(Q30 - a) << 30));
    d  = (DIAMETER * vector_angle(ra, rb) + (64'sd1 << 29)) >>> 30;
    if (d < 0) d = 0;
    if (d > KM_CAP) d = KM_CAP;
    return d[14:0];
  endfunction

  task automatic report(input string what, input longint want, input longint got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    n_fail++;
  endtask

  always @(posedge clk) begin
    logic [14:0] want;
    if (!rst_n) begin
      org_lat   = longint'(gcd_pkg::ORIGIN_LAT_RESET);
      org_lng   = longint'(gcd_pkg::ORIGIN_LNG_RESET);
      n_fail    = 0;
      n_checked = 0;
      km_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (km_q.size() == 0) begin
          report("unexpected distance", -1, out_dist_km);
        end else begin
          want = km_q.pop_front();
          if (out_dist_km !== want) report("dist_km", want, out_dist_km);
        end
      end
      if (in_valid && in_ready)
        km_q.push_back(haversine_km(longint'(in_target_lat), longint'(in_target_lng)));
      if (cfg_we) begin
        if (cfg_index == gcd_pkg::REG_ORIGIN_LAT)
          org_lat = longint'($signed(cfg_wdata[23:0]));
        else if (cfg_index == gcd_pkg::REG_ORIGIN_LNG)
          org_lng = longint'($signed(cfg_wdata));
      end
    end
    n_pending = km_q.size();
  end

endmodule

// ----- dv/great_circle_distance_core_tb.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance core testbench
// Drives targets under several origin settings, with random gaps on both
// channels; the checker predicts every distance and counts mismatches.
// ----------------------------------------------------------------------------
module great_circle_distance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LIMIT    = 600000;
  localparam int  DRAIN    = 130;
  localparam int  LAT_MAX  = 5898240;
  localparam int  LNG_MAX  = 11796480;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [23:0] in_target_lat = '0;
  logic signed [24:0] in_target_lng = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [14:0]        out_dist_km;
  logic               cfg_we = 0;
  logic [0:0]         cfg_index = gcd_pkg::REG_ORIGIN_LAT;
  logic [24:0]        cfg_wdata = '0;
  int                 n_fail, n_pending, n_checked;
  int                 cycles = 0;
  int                 n_sent = 0;
  bit                 gaps_on = 1;
  int                 cur_lat = -1341502;
  int                 cur_lng = -3579584;

  always #6 clk = ~clk;

  great_circle_distance_core u_top (.*);

  great_circle_distance_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    out_ready <= gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d distances still due", cycles, n_pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_target(input int lat, input int lng);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_target_lat <= lat[23:0];
    in_target_lng <= lng[24:0];
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // wait for the pipeline to empty, then write the origin
  task automatic set_origin(input int lat, input int lng);
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= gcd_pkg::REG_ORIGIN_LAT;
    cfg_wdata <= 25'(lat);
    @(posedge clk);
    cfg_index <= gcd_pkg::REG_ORIGIN_LNG;
    cfg_wdata <= lng[24:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lat = lat;
    cur_lng = lng;
  endtask

  task automatic random_targets(input int count);
    int lat, lng, sel;
    for (int i = 0; i < count; i++) begin
      gaps_on = !(i >= count / 3 && i < count / 3 + 60);
      sel = $urandom_range(99);
      if (sel < 60) begin
        lat = $urandom_range(2 * LAT_MAX) - LAT_MAX;
        lng = $urandom_range(2 * LNG_MAX) - LNG_MAX;
      end else if (sel < 75) begin
        // close to the origin
        lat = cur_lat + int'($urandom_range(2000)) - 1000;
        lng = cur_lng + int'($urandom_range(2000)) - 1000;
      end else if (sel < 85) begin
        // near the antipode
        lat = -cur_lat + int'($urandom_range(4000)) - 2000;
        lng = cur_lng + (cur_lng < 0 ? LNG_MAX : -LNG_MAX) + int'($urandom_range(4000)) - 2000;
      end else begin
        lat = int'($signed(24'($urandom)));
        lng = int'($signed(25'($urandom)));
      end
      send_target(lat, lng);
    end
    gaps_on = 1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed targets against the reset origin
    send_target(0, 0);
    send_target(cur_lat, cur_lng);
    send_target(-cur_lat, cur_lng + LNG_MAX);
    send_target(LAT_MAX, LNG_MAX);
    send_target(-LAT_MAX, -LNG_MAX);
    send_target(LAT_MAX, -LNG_MAX);
    send_target(24'sh7FFFFF, 25'sh0FFFFFF);
    send_target(-24'sh800000, -25'sh1000000);
    send_target(cur_lat, cur_lng + 2 * LNG_MAX);
    send_target(cur_lat + 1, cur_lng);
    send_target(-1, -1);
    send_target(cur_lat, -cur_lng);

    set_origin(LAT_MAX, -LNG_MAX);
    send_target(-LAT_MAX, LNG_MAX);
    send_target(LAT_MAX, LNG_MAX);
    send_target(0, 0);
    random_targets(260);

    set_origin(-LAT_MAX, LNG_MAX);
    send_target(LAT_MAX, 0);
    send_target(-LAT_MAX, -LNG_MAX);
    random_targets(260);

    set_origin(0, 0);
    send_target(0, LNG_MAX);
    send_target(0, 0);
    random_targets(260);

    set_origin($urandom_range(2 * LAT_MAX) - LAT_MAX, $urandom_range(2 * LNG_MAX) - LNG_MAX);
    random_targets(280);
    in_valid <= 1'b0;

    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d targets over five origin settings; %0d distances checked.",
             n_sent, n_checked);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
